/* design/tlc_pkg.sv */
// Shared constants, controller/datapath interface structs and LFSR helpers
// for the two-level cache tag model. No dependencies.
package tlc_pkg;

  localparam int ADDR_W     = 32;
  localparam int CNT_W      = 32;
  localparam int LFSR_W     = 16;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  localparam int LINE_BYTES_DEF = 64;
  localparam int L1_SETS_DEF    = 512;
  localparam int L1_WAYS_DEF    = 2;
  localparam int L2_SETS_DEF    = 2048;
  localparam int L2_WAYS_DEF    = 8;

  localparam int RECIP_SHIFT = 20;

  localparam logic              REG_LFSR_SEED = 1'b0;
  localparam logic [LFSR_W-1:0] SEED_RESET    = 16'h0001;

  typedef struct packed {
    logic clear;
    logic lookup;
    logic evaluate;
    logic victim;
    logic fill;
    logic load_result;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic need_victim;
    logic result_free;
  } dp_status_t;

  function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] v);
    logic fb;
    fb = v[0] ^ v[2] ^ v[3] ^ v[5];
    return {fb, v[LFSR_W-1:1]};
  endfunction

  function automatic logic [LFSR_W-1:0] seed_value(input logic [LFSR_W-1:0] s);
    return (s == '0) ? LFSR_W'(1) : s;
  endfunction

endpackage

/* design/tlc_ctrl.sv */
// Sequencing state machine for the cache tag model: clearing pass, lookup,
// victim selection, fill and result transfer. Depends on tlc_pkg.
module tlc_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  access_valid,
  output logic                  access_stall,
  input  tlc_pkg::dp_status_t   status,
  output tlc_pkg::ctrl_cmd_t    cmd
);

  typedef enum logic [2:0] {
    CLEAR,
    IDLE,
    LOOK,
    VICTIM,
    WRITE,
    HOLD
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      CLEAR: begin
        cmd.clear = 1'b1;
        if (status.clear_last) state_next = IDLE;
      end
      IDLE: begin
        if (access_valid) begin
          cmd.lookup = 1'b1;
          state_next = LOOK;
        end
      end
      LOOK: begin
        cmd.evaluate = 1'b1;
        state_next   = status.need_victim ? VICTIM : WRITE;
      end
      VICTIM: begin
        cmd.victim = 1'b1;
        state_next = WRITE;
      end
      WRITE: begin
        cmd.fill = 1'b1;
        if (status.result_free) begin
          cmd.load_result = 1'b1;
          state_next      = IDLE;
        end else begin
          state_next = HOLD;
        end
      end
      HOLD: begin
        if (status.result_free) begin
          cmd.load_result = 1'b1;
          state_next      = IDLE;
        end
      end
      default: state_next = CLEAR;
    endcase
  end

  assign access_stall = (state != IDLE);

endmodule

/* design/tlc_datapath.sv */
// Tag memories, hit detection, replacement LFSR, victim modulo, counters and
// result register of the cache tag model. Depends on tlc_pkg.
module tlc_datapath #(
  parameter int LINE_BYTES = tlc_pkg::LINE_BYTES_DEF,
  parameter int L1_SETS    = tlc_pkg::L1_SETS_DEF,
  parameter int L1_WAYS    = tlc_pkg::L1_WAYS_DEF,
  parameter int L2_SETS    = tlc_pkg::L2_SETS_DEF,
  parameter int L2_WAYS    = tlc_pkg::L2_WAYS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  tlc_pkg::ctrl_cmd_t          cmd,
  output tlc_pkg::dp_status_t         status,
  input  logic [tlc_pkg::ADDR_W-1:0]  access_addr,
  input  logic                        lfsr_load,
  input  logic [tlc_pkg::LFSR_W-1:0]  lfsr_load_value,
  input  logic                        result_stall,
  output logic                        result_valid,
  output logic                        l1_hit,
  output logic                        l2_hit,
  output logic [tlc_pkg::CNT_W-1:0]   l1_hit_count,
  output logic [tlc_pkg::CNT_W-1:0]   l1_miss_count,
  output logic [tlc_pkg::CNT_W-1:0]   l2_hit_count,
  output logic [tlc_pkg::CNT_W-1:0]   l2_miss_count
);

  localparam int AW       = tlc_pkg::ADDR_W;
  localparam int LW       = tlc_pkg::LFSR_W;
  localparam int CW       = tlc_pkg::CNT_W;
  localparam int OFF_W    = $clog2(LINE_BYTES);
  localparam int S1_W     = $clog2(L1_SETS);
  localparam int S2_W     = $clog2(L2_SETS);
  localparam int T1_W     = AW - OFF_W - S1_W;
  localparam int T2_W     = AW - OFF_W - S2_W;
  localparam int W1_W     = (L1_WAYS > 1) ? $clog2(L1_WAYS) : 1;
  localparam int W2_W     = (L2_WAYS > 1) ? $clog2(L2_WAYS) : 1;
  localparam int ROW1_W   = L1_WAYS * (1 + T1_W);
  localparam int ROW2_W   = L2_WAYS * (1 + T2_W);
  localparam int MAX_SETS = (L1_SETS > L2_SETS) ? L1_SETS : L2_SETS;
  localparam int CLR_W    = $clog2(MAX_SETS);
  localparam int RECIP_W  = tlc_pkg::RECIP_SHIFT + 1;
  localparam int PROD_W   = LW + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP1 = RECIP_W'((1 << tlc_pkg::RECIP_SHIFT) / L1_WAYS);
  localparam logic [RECIP_W-1:0] RECIP2 = RECIP_W'((1 << tlc_pkg::RECIP_SHIFT) / L2_WAYS);
  localparam logic [LW-1:0]      WAYS1  = LW'(L1_WAYS);
  localparam logic [LW-1:0]      WAYS2  = LW'(L2_WAYS);

  logic [ROW1_W-1:0] l1_mem [L1_SETS];
  logic [ROW2_W-1:0] l2_mem [L2_SETS];

  logic [ROW1_W-1:0] l1_row, l1_row_new;
  logic [ROW2_W-1:0] l2_row, l2_row_new;
  logic [AW-1:0]     addr_q;
  logic [CLR_W-1:0]  clr_cnt;
  logic [LW-1:0]     lfsr, lfsr_a, lfsr_b;

  logic [S1_W-1:0]   set1;
  logic [S2_W-1:0]   set2;
  logic [T1_W-1:0]   tag1;
  logic [T2_W-1:0]   tag2;

  logic              hit1, hit2, full1, full2;
  logic [W1_W-1:0]   inv1;
  logic [W2_W-1:0]   inv2;
  logic              fill1, fill2, vic1, vic2;

  logic              hit1_q, hit2_q, fill1_q, fill2_q, full1_q, full2_q;
  logic [W1_W-1:0]   inv1_q;
  logic [W2_W-1:0]   inv2_q;
  logic [LW-1:0]     rnd1_q, rnd2_q, q1_q, q2_q;
  logic [PROD_W-1:0] prod1, prod2;
  logic [LW-1:0]     rem1, rem2;
  logic [W1_W-1:0]   way1;
  logic [W2_W-1:0]   way2;

  logic [CW-1:0]     cnt_l1_hit, cnt_l1_miss, cnt_l2_hit, cnt_l2_miss;

  function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  assign set1 = addr_q[OFF_W +: S1_W];
  assign set2 = addr_q[OFF_W +: S2_W];
  assign tag1 = addr_q[OFF_W + S1_W +: T1_W];
  assign tag2 = addr_q[OFF_W + S2_W +: T2_W];

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      if ({1'b0, clr_cnt} < (CLR_W + 1)'(L1_SETS)) l1_mem[clr_cnt[S1_W-1:0]] <= '0;
    end else if (cmd.fill && fill1_q) begin
      l1_mem[set1] <= l1_row_new;
    end
    if (cmd.lookup) l1_row <= l1_mem[access_addr[OFF_W +: S1_W]];
  end

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      if ({1'b0, clr_cnt} < (CLR_W + 1)'(L2_SETS)) l2_mem[clr_cnt[S2_W-1:0]] <= '0;
    end else if (cmd.fill && fill2_q) begin
      l2_mem[set2] <= l2_row_new;
    end
    if (cmd.lookup) l2_row <= l2_mem[access_addr[OFF_W +: S2_W]];
  end

  always_ff @(posedge clk) begin
    if (cmd.lookup) addr_q <= access_addr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  always_comb begin
    hit1 = 1'b0;
    inv1 = '0;
    for (int w = 0; w < L1_WAYS; w++) begin
      if (l1_row[w] && (l1_row[L1_WAYS + w * T1_W +: T1_W] == tag1)) hit1 = 1'b1;
    end
    for (int w = L1_WAYS - 1; w >= 0; w--) begin
      if (!l1_row[w]) inv1 = W1_W'(w);
    end
    full1 = &l1_row[L1_WAYS-1:0];
  end

  always_comb begin
    hit2 = 1'b0;
    inv2 = '0;
    for (int w = 0; w < L2_WAYS; w++) begin
      if (l2_row[w] && (l2_row[L2_WAYS + w * T2_W +: T2_W] == tag2)) hit2 = 1'b1;
    end
    for (int w = L2_WAYS - 1; w >= 0; w--) begin
      if (!l2_row[w]) inv2 = W2_W'(w);
    end
    full2 = &l2_row[L2_WAYS-1:0];
  end

  assign fill1  = !hit1;
  assign fill2  = !hit1 && !hit2;
  assign vic1   = fill1 && full1;
  assign vic2   = fill2 && full2;
  assign lfsr_a = tlc_pkg::lfsr_step(lfsr);
  assign lfsr_b = tlc_pkg::lfsr_step(lfsr_a);

  // L2 takes the first step when both levels replace
  always_ff @(posedge clk) begin
    if (cmd.evaluate) begin
      hit1_q  <= hit1;
      hit2_q  <= !hit1 && hit2;
      fill1_q <= fill1;
      fill2_q <= fill2;
      full1_q <= full1;
      full2_q <= full2;
      inv1_q  <= inv1;
      inv2_q  <= inv2;
      rnd2_q  <= lfsr_a;
      rnd1_q  <= vic2 ? lfsr_b : lfsr_a;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lfsr <= tlc_pkg::seed_value(tlc_pkg::SEED_RESET);
    end else if (lfsr_load) begin
      lfsr <= lfsr_load_value;
    end else if (cmd.evaluate && (vic1 || vic2)) begin
      lfsr <= (vic1 && vic2) ? lfsr_b : lfsr_a;
    end
  end

  assign prod1 = {{RECIP_W{1'b0}}, rnd1_q} * {{LW{1'b0}}, RECIP1};
  assign prod2 = {{RECIP_W{1'b0}}, rnd2_q} * {{LW{1'b0}}, RECIP2};

  always_ff @(posedge clk) begin
    if (cmd.victim) begin
      q1_q <= prod1[tlc_pkg::RECIP_SHIFT +: LW];
      q2_q <= prod2[tlc_pkg::RECIP_SHIFT +: LW];
    end
  end

  // quotient estimate is low by at most one: one correction step
  always_comb begin
    rem1 = rnd1_q - LW'(q1_q * WAYS1);
    if (rem1 >= WAYS1) rem1 = rem1 - WAYS1;
    rem2 = rnd2_q - LW'(q2_q * WAYS2);
    if (rem2 >= WAYS2) rem2 = rem2 - WAYS2;
    way1 = full1_q ? rem1[W1_W-1:0] : inv1_q;
    way2 = full2_q ? rem2[W2_W-1:0] : inv2_q;
    l1_row_new = l1_row;
    l1_row_new[way1] = 1'b1;
    l1_row_new[L1_WAYS + way1 * T1_W +: T1_W] = tag1;
    l2_row_new = l2_row;
    l2_row_new[way2] = 1'b1;
    l2_row_new[L2_WAYS + way2 * T2_W +: T2_W] = tag2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_l1_hit  <= '0;
      cnt_l1_miss <= '0;
      cnt_l2_hit  <= '0;
      cnt_l2_miss <= '0;
    end else if (cmd.evaluate) begin
      if (hit1) begin
        cnt_l1_hit <= sat_inc(cnt_l1_hit);
        cnt_l2_hit <= sat_inc(cnt_l2_hit);
      end else begin
        cnt_l1_miss <= sat_inc(cnt_l1_miss);
        if (hit2) begin
          cnt_l2_hit <= sat_inc(cnt_l2_hit);
        end else begin
          cnt_l2_miss <= sat_inc(cnt_l2_miss);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.load_result) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_result) begin
      l1_hit        <= hit1_q;
      l2_hit        <= hit2_q;
      l1_hit_count  <= cnt_l1_hit;
      l1_miss_count <= cnt_l1_miss;
      l2_hit_count  <= cnt_l2_hit;
      l2_miss_count <= cnt_l2_miss;
    end
  end

  assign status.clear_last  = (clr_cnt == CLR_W'(MAX_SETS - 1));
  assign status.need_victim = vic1 || vic2;
  assign status.result_free = !result_valid || !result_stall;

endmodule

/* design/two_level_cache_tag_model.sv */
// Top level of the two-level cache tag model: APB seed register, controller
// and datapath. Depends on tlc_pkg, tlc_ctrl and tlc_datapath.
//
// After reset the block clears the tag memories over max(L1_SETS, L2_SETS)
// set indices (2048 by default) with access_stall high. Each access then
// runs through set read of both levels, hit check and fill write, with a
// victim step before it when a full set needs a replacement way, since the
// way is derived from the LFSR through a registered reciprocal multiply. One
// access is in flight at a time; the result register holds a finished
// transfer while the next access is accepted. The lfsr_seed register at byte
// address 0 reloads the replacement LFSR when written (zero loads as 1).
module two_level_cache_tag_model #(
  parameter int LINE_BYTES = tlc_pkg::LINE_BYTES_DEF,
  parameter int L1_SETS    = tlc_pkg::L1_SETS_DEF,
  parameter int L1_WAYS    = tlc_pkg::L1_WAYS_DEF,
  parameter int L2_SETS    = tlc_pkg::L2_SETS_DEF,
  parameter int L2_WAYS    = tlc_pkg::L2_WAYS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tlc_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [tlc_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [tlc_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready,
  input  logic                            access_valid,
  output logic                            access_stall,
  input  logic [tlc_pkg::ADDR_W-1:0]      access_addr,
  output logic                            result_valid,
  input  logic                            result_stall,
  output logic                            l1_hit,
  output logic                            l2_hit,
  output logic [tlc_pkg::CNT_W-1:0]       l1_hit_count,
  output logic [tlc_pkg::CNT_W-1:0]       l1_miss_count,
  output logic [tlc_pkg::CNT_W-1:0]       l2_hit_count,
  output logic [tlc_pkg::CNT_W-1:0]       l2_miss_count
);

  tlc_pkg::ctrl_cmd_t             cmd;
  tlc_pkg::dp_status_t            status;
  logic [tlc_pkg::LFSR_W-1:0]     lfsr_seed;
  logic                           seed_sel;
  logic                           seed_wr;

  assign pready   = 1'b1;
  assign seed_sel = (paddr[2] == tlc_pkg::REG_LFSR_SEED);
  assign seed_wr  = psel && penable && pwrite && pready && seed_sel;
  assign prdata   = seed_sel ? tlc_pkg::APB_DATA_W'(lfsr_seed) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      lfsr_seed <= tlc_pkg::SEED_RESET;
    end else if (seed_wr) begin
      lfsr_seed <= pwdata[tlc_pkg::LFSR_W-1:0];
    end
  end

  tlc_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .access_valid (access_valid),
    .access_stall (access_stall),
    .status       (status),
    .cmd          (cmd)
  );

  tlc_datapath #(
    .LINE_BYTES (LINE_BYTES),
    .L1_SETS    (L1_SETS),
    .L1_WAYS    (L1_WAYS),
    .L2_SETS    (L2_SETS),
    .L2_WAYS    (L2_WAYS)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .access_addr     (access_addr),
    .lfsr_load       (seed_wr),
    .lfsr_load_value (tlc_pkg::seed_value(pwdata[tlc_pkg::LFSR_W-1:0])),
    .result_stall    (result_stall),
    .result_valid    (result_valid),
    .l1_hit          (l1_hit),
    .l2_hit          (l2_hit),
    .l1_hit_count    (l1_hit_count),
    .l1_miss_count   (l1_miss_count),
    .l2_hit_count    (l2_hit_count),
    .l2_miss_count   (l2_miss_count)
  );

  a_hit_exclusive: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(l1_hit && l2_hit))
    else $error("l1_hit and l2_hit both set");

  a_l2_count_covers_l1: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (l2_hit_count >= l1_hit_count))
    else $error("l2_hit_count below l1_hit_count");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (access_valid && !access_stall) |=> access_stall)
    else $error("second access taken while one is in flight");

  a_result_after_lookup: assert property (@(posedge clk) disable iff (rst)
    (access_valid && !access_stall) |=> ##1 !(result_valid && $rose(result_valid)))
    else $error("result appeared too early");

endmodule
